FILE: src/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
// Used by i2cms_step and i2c_master_bit_sequencer; no dependencies.
package i2cms_pkg;

    // Command codes carried in the func field
    localparam logic [2:0] CMD_IDLE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_SENDACK = 3'd5;
    localparam logic [2:0] CMD_RECVACK = 3'd6;

    // Sequencer phase codes
    localparam logic [2:0] PH_0 = 3'd0;
    localparam logic [2:0] PH_1 = 3'd1;
    localparam logic [2:0] PH_2 = 3'd2;
    localparam logic [2:0] PH_3 = 3'd3;
    localparam logic [2:0] PH_4 = 3'd4;
    localparam logic [2:0] PH_5 = 3'd5;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam int         DELAY_W       = 16;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [2:0]         phase;
        logic [3:0]         bit_idx;
        logic [7:0]         shreg;
        logic [DELAY_W-1:0] dcnt;
        logic               scl;
        logic               sda;
        logic               sda_drv;
        logic               ack;
        logic [7:0]         rd_byte;
    } seq_state_t;

    // Result fields from the highest bit down; padded to 16 bits on the port
    typedef struct packed {
        logic       rejected;
        logic       ack_seen;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } seq_result_t;

endpackage

FILE: src/i2c_master_bit_sequencer.sv
// I2C master bit sequencer top level: stream ports, state and result registers.
// Depends on i2cms_pkg and i2cms_step.
//
//  channel   | direction | payload
//  s_axis    | in        | tuser: func[2:0]; tdata: data_byte, ack_level, sda_in
//  m_axis    | out       | tdata: scl, sda, drive, busy, done, read_data, ack, rejected
//  cfg       | in        | cfg_wdata: delay_ticks, written when cfg_we is high
//
// One transaction in gives one transaction out; the whole item is evaluated
// combinationally from the state registers, so one item per cycle is taken
// while no result is stalled; the result is registered, held until taken,
// and a new item is accepted in the same cycle that the old result leaves.
// Reset (rst_n low) returns the sequencer to idle with SCL/SDA high and driven,
// and delay_ticks to one.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // data_byte[7:0], ack_level[8], sda_in[9]
    input  logic [2:0]          s_axis_tuser,   // func[2:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // scl_level[0], sda_level[1], sda_drive[2],
                                                // busy_res[3], done_res[4], read_data[12:5],
                                                // ack_seen[13], rejected[14]
    input  logic                cfg_we,
    input  logic [DELAY_W-1:0]  cfg_wdata
);

    seq_state_t         state_reg;
    seq_state_t         state_next;
    seq_result_t        res_reg;
    seq_result_t        res_next;
    logic               out_valid_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               in_accept;

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    i2cms_step u_step (
        .cur         (state_reg),
        .func        (s_axis_tuser),
        .data_byte   (s_axis_tdata[7:0]),
        .ack_level   (s_axis_tdata[8]),
        .sda_in      (s_axis_tdata[9]),
        .delay_ticks (delay_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            delay_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cmd     <= CMD_IDLE;
            state_reg.phase   <= PH_0;
            state_reg.bit_idx <= 4'd0;
            state_reg.shreg   <= 8'd0;
            state_reg.dcnt    <= '0;
            state_reg.scl     <= 1'b1;
            state_reg.sda     <= 1'b1;
            state_reg.sda_drv <= 1'b1;
            state_reg.ack     <= 1'b0;
            state_reg.rd_byte <= 8'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
                state_reg <= state_next;
            // hold the result until the downstream side takes it
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg};

    // Checks on sequencer state and result coherence
    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.cmd == CMD_IDLE) |-> (state_reg.dcnt == '0))
        else $error("delay counter running while idle");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase <= PH_5) && (state_reg.bit_idx <= BITS_PER_BYTE))
        else $error("phase or bit index out of range");

    a_no_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && state_reg.cmd == CMD_IDLE) |=> !res_reg.rejected)
        else $error("command rejected while idle");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done flagged on a busy result");

    a_busy_matches: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (res_reg.busy_res == (state_reg.cmd != CMD_IDLE)))
        else $error("busy flag disagrees with sequencer state");

endmodule

FILE: src/i2cms_step.sv
// Next-state logic of the I2C master bit sequencer: one item per evaluation.
// Depends on i2cms_pkg for codes and the state/result structs.
module i2cms_step
    import i2cms_pkg::*;
(
    input  seq_state_t         cur,
    input  logic [2:0]         func,
    input  logic [7:0]         data_byte,
    input  logic               ack_level,
    input  logic               sda_in,
    input  logic [DELAY_W-1:0] delay_ticks,
    output seq_state_t         nxt,
    output seq_result_t        res
);

    seq_state_t n;
    logic       is_cmd;
    logic       do_step;
    logic       fin;
    logic       rej;
    logic [2:0] ph;
    logic [3:0] bi_inc;

    always_comb
    begin
        n       = cur;
        is_cmd  = (func >= CMD_START) && (func <= CMD_RECVACK);
        do_step = 1'b0;
        fin     = 1'b0;
        rej     = 1'b0;
        bi_inc  = 4'd0;

        if (cur.cmd != CMD_IDLE)
        begin
            rej = is_cmd;
            if (cur.dcnt > DELAY_W'(1))
            begin
                n.dcnt = cur.dcnt - DELAY_W'(1);
            end
            else
            begin
                n.dcnt  = '0;
                do_step = 1'b1;
            end
        end
        else if (is_cmd)
        begin
            n.cmd     = func;
            n.phase   = PH_0;
            n.bit_idx = 4'd0;
            if (func == CMD_WRITE)
                n.shreg = data_byte;
            if (func == CMD_SENDACK)
                n.sda = ack_level;
            do_step = 1'b1;
        end

        ph = n.phase;

        if (do_step)
        begin
            unique case (n.cmd)
                CMD_START:
                begin
                    if (ph == PH_0)
                    begin
                        n.sda_drv = 1'b1; n.scl = 1'b1; n.sda = 1'b1; n.phase = PH_1;
                    end
                    else if (ph == PH_1)
                    begin
                        n.sda = 1'b0; n.phase = PH_2;
                    end
                    else
                    begin
                        n.scl = 1'b0; fin = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    if (ph == PH_0)
                    begin
                        n.sda_drv = 1'b1; n.scl = 1'b1; n.sda = 1'b0; n.phase = PH_1;
                    end
                    else if (ph == PH_1)
                    begin
                        n.sda = 1'b1; n.phase = PH_2;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                CMD_WRITE:
                begin
                    if (ph == PH_2)
                    begin
                        // shift out the next bit, or turn to the acknowledge slot
                        bi_inc    = n.bit_idx + 4'd1;
                        n.shreg   = {n.shreg[6:0], 1'b0};
                        n.bit_idx = bi_inc;
                        ph        = (bi_inc >= BITS_PER_BYTE) ? PH_3 : PH_0;
                        if (bi_inc >= BITS_PER_BYTE)
                        begin
                            n.scl = 1'b0; n.sda_drv = 1'b0; n.phase = PH_3;
                        end
                        else
                        begin
                            n.sda_drv = 1'b1; n.scl = 1'b0; n.sda = n.shreg[7];
                            n.phase = PH_1;
                        end
                    end
                    else if (ph == PH_0)
                    begin
                        n.sda_drv = 1'b1; n.scl = 1'b0; n.sda = n.shreg[7]; n.phase = PH_1;
                    end
                    else if (ph == PH_1)
                    begin
                        n.scl = 1'b1; n.phase = PH_2;
                    end
                    else if (ph == PH_3)
                    begin
                        n.scl = 1'b1; n.phase = PH_4;
                    end
                    else if (ph == PH_4)
                    begin
                        n.ack = ~sda_in; n.scl = 1'b0; n.phase = PH_5;
                    end
                    else
                    begin
                        n.sda_drv = 1'b1; fin = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (ph == PH_0)
                    begin
                        n.sda_drv = 1'b0; n.scl = 1'b0; n.shreg = 8'd0; n.bit_idx = 4'd0;
                        n.phase = PH_1;
                    end
                    else if (ph == PH_1)
                    begin
                        n.scl = 1'b1; n.phase = PH_2;
                    end
                    else if (ph == PH_2)
                    begin
                        bi_inc    = n.bit_idx + 4'd1;
                        n.shreg   = {n.shreg[6:0], sda_in};
                        n.scl     = 1'b0;
                        n.bit_idx = bi_inc;
                        n.phase   = (bi_inc < BITS_PER_BYTE) ? PH_1 : PH_3;
                    end
                    else if (ph == PH_3)
                    begin
                        n.sda_drv = 1'b1; n.phase = PH_4;
                    end
                    else
                    begin
                        n.rd_byte = n.shreg; fin = 1'b1;
                    end
                end
                CMD_SENDACK:
                begin
                    if (ph == PH_0)
                    begin
                        n.phase = PH_1; n.scl = 1'b1; n.sda_drv = 1'b1;
                    end
                    else if (ph == PH_1)
                    begin
                        n.scl = 1'b0; n.phase = PH_2;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                CMD_RECVACK:
                begin
                    if (ph == PH_0)
                    begin
                        n.sda_drv = 1'b0; n.scl = 1'b1; n.phase = PH_1;
                    end
                    else if (ph == PH_1)
                    begin
                        n.ack = ~sda_in; n.scl = 1'b0; n.phase = PH_2;
                    end
                    else
                    begin
                        n.sda_drv = 1'b1; fin = 1'b1;
                    end
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase

            if (fin)
            begin
                n.cmd   = CMD_IDLE;
                n.phase = PH_0;
                n.dcnt  = '0;
            end
            else
            begin
                // reload the delay unit; a zero setting counts as one tick
                n.dcnt = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
            end
        end

        nxt           = n;
        res.scl_level = n.scl;
        res.sda_level = n.sda;
        res.sda_drive = n.sda_drv;
        res.busy_res  = (n.cmd != CMD_IDLE);
        res.done_res  = fin & (cur.cmd != CMD_IDLE);
        res.read_data = n.rd_byte;
        res.ack_seen  = n.ack;
        res.rejected  = rej;
    end

endmodule
